FILE: rtl/core/vohw_pkg.sv
// ----------------------------------------------------------------------------
// vohw_pkg
// Shared types and constants for the video object layer header writer.
// ----------------------------------------------------------------------------
package vohw_pkg;

  // Field widths
  localparam int SIZE_W  = 13;
  localparam int RES_W   = 16;
  localparam int RATE_W  = 18;
  localparam int BITS_W  = 5;
  localparam int POS_W   = 5;
  localparam int BYTE_W  = 8;

  // Divider geometry: numerator 10000*res + rate, denominator 10*rate
  localparam int NUM_W     = 30;
  localparam int DEN_W     = 22;
  localparam int DIV_CNT_W = 5;

  // Header layout
  localparam int HDR_W      = 168;  // 21 bytes, padded
  localparam int PREFIX_W   = 107;  // start codes through the fixed rate flag after res
  localparam int TAIL_W     = 40;   // marker, width, marker, height, flags
  localparam int VAR_W      = RES_W + TAIL_W;
  localparam int PAD_W      = HDR_W - PREFIX_W - VAR_W;
  localparam int BYTE_BIAS  = 154;  // 147 fixed bits plus 7 for rounding up

  localparam logic [26:0] OBJ_CODE   = 27'h0000008;
  localparam logic [27:0] LAYER_CODE = 28'h0000012;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [RES_W-1:0]  res;
    logic [BITS_W-1:0] inc_bits;
    logic [RES_W-1:0]  inc;
  } job_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_SEND
  } back_state_t;

endpackage

FILE: rtl/core/vohw_req_if.sv
// ----------------------------------------------------------------------------
// vohw_req_if
// Request channel: picture geometry and timing for one header.
// ----------------------------------------------------------------------------
interface vohw_req_if;
  logic                             valid;
  logic                             ready;
  logic [vohw_pkg::SIZE_W-1:0]      picture_width;
  logic [vohw_pkg::SIZE_W-1:0]      picture_height;
  logic [vohw_pkg::RES_W-1:0]       time_resolution;
  logic [vohw_pkg::RATE_W-1:0]      rate_milli;

  modport source (
    output valid, picture_width, picture_height, time_resolution, rate_milli,
    input  ready
  );
  modport sink (
    input  valid, picture_width, picture_height, time_resolution, rate_milli,
    output ready
  );
endinterface

FILE: rtl/core/vohw_hdr_if.sv
// ----------------------------------------------------------------------------
// vohw_hdr_if
// Header byte channel: one header byte per word.
// ----------------------------------------------------------------------------
interface vohw_hdr_if;
  logic                          valid;
  logic                          ready;
  logic [vohw_pkg::BYTE_W-1:0]   header_byte;
  logic [vohw_pkg::POS_W-1:0]    byte_position;
  logic                          final_byte;

  modport source (
    output valid, header_byte, byte_position, final_byte,
    input  ready
  );
  modport sink (
    input  valid, header_byte, byte_position, final_byte,
    output ready
  );
endinterface

FILE: rtl/core/vohw_front.sv
// ----------------------------------------------------------------------------
// vohw_front
// Accepts a request, rounds the picture size, finds the increment width and
// runs a one-bit-per-cycle restoring divider for the time increment.
// ----------------------------------------------------------------------------
module vohw_front (
  input  logic                 clk,
  input  logic                 rst,
  vohw_req_if.sink             req,
  output logic                 push_valid,
  input  logic                 push_ready,
  output vohw_pkg::job_t       push_job
);

  vohw_pkg::front_state_t state, state_next;

  logic [vohw_pkg::SIZE_W-1:0]    width, height;
  logic [vohw_pkg::RES_W-1:0]     res;
  logic [vohw_pkg::RATE_W-1:0]    rate;
  logic [vohw_pkg::BITS_W-1:0]    inc_bits;
  logic                           rate_zero;
  logic [vohw_pkg::NUM_W-1:0]     quo;
  logic [vohw_pkg::DEN_W-1:0]     den;
  logic [vohw_pkg::DEN_W-1:0]     rem;
  logic [vohw_pkg::DIV_CNT_W-1:0] div_cnt;

  logic                           accept;
  logic [vohw_pkg::SIZE_W:0]      width_sum, height_sum;
  logic [vohw_pkg::RES_W-1:0]     res_m1;
  logic [vohw_pkg::BITS_W-1:0]    bits_calc;
  logic [vohw_pkg::DEN_W:0]       shifted;
  logic [vohw_pkg::DEN_W+1:0]     diff;
  logic                           ge;

  assign accept    = req.valid && req.ready;
  assign req.ready = (state == vohw_pkg::F_IDLE);

  // Round to the nearest multiple of 16, keep 13 bits
  assign width_sum  = {1'b0, req.picture_width} + (vohw_pkg::SIZE_W+1)'(8);
  assign height_sum = {1'b0, req.picture_height} + (vohw_pkg::SIZE_W+1)'(8);

  // Increment width: bit length of res-1, at least one
  assign res_m1 = req.time_resolution - vohw_pkg::RES_W'(1);
  always_comb begin
    bits_calc = vohw_pkg::BITS_W'(1);
    if (req.time_resolution > vohw_pkg::RES_W'(1)) begin
      for (int i = 0; i < vohw_pkg::RES_W; i++) begin
        if (res_m1[i]) bits_calc = vohw_pkg::BITS_W'(i + 1);
      end
    end
  end

  // Restoring divide step
  assign shifted = {rem, quo[vohw_pkg::NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den};
  assign ge      = !diff[vohw_pkg::DEN_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vohw_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      vohw_pkg::F_IDLE: begin
        if (accept) state_next = vohw_pkg::F_MUL;
      end
      vohw_pkg::F_MUL: begin
        state_next = vohw_pkg::F_DIV;
      end
      vohw_pkg::F_DIV: begin
        if (div_cnt == vohw_pkg::DIV_CNT_W'(vohw_pkg::NUM_W - 1)) begin
          state_next = vohw_pkg::F_PUSH;
        end
      end
      vohw_pkg::F_PUSH: begin
        if (push_ready) state_next = vohw_pkg::F_IDLE;
      end
      default: state_next = vohw_pkg::F_IDLE;
    endcase
  end

  // Capture the request, then scale, then divide
  always_ff @(posedge clk) begin
    if (accept) begin
      width     <= {width_sum[vohw_pkg::SIZE_W-1:4], 4'b0000};
      height    <= {height_sum[vohw_pkg::SIZE_W-1:4], 4'b0000};
      res       <= req.time_resolution;
      rate      <= req.rate_milli;
      rate_zero <= (req.rate_milli == '0);
      inc_bits  <= bits_calc;
    end
    if (state == vohw_pkg::F_MUL) begin
      quo     <= vohw_pkg::NUM_W'(res) * vohw_pkg::NUM_W'(10000)
                 + vohw_pkg::NUM_W'(rate);
      den     <= vohw_pkg::DEN_W'(rate) * vohw_pkg::DEN_W'(10);
      rem     <= '0;
      div_cnt <= '0;
    end
    if (state == vohw_pkg::F_DIV) begin
      rem     <= ge ? diff[vohw_pkg::DEN_W-1:0] : shifted[vohw_pkg::DEN_W-1:0];
      quo     <= {quo[vohw_pkg::NUM_W-2:0], ge};
      div_cnt <= div_cnt + vohw_pkg::DIV_CNT_W'(1);
    end
  end

  // Hand the finished job to the queue
  assign push_valid        = (state == vohw_pkg::F_PUSH);
  assign push_job.width    = width;
  assign push_job.height   = height;
  assign push_job.res      = res;
  assign push_job.inc_bits = inc_bits;
  assign push_job.inc      = rate_zero ? '1 : quo[vohw_pkg::RES_W-1:0];

endmodule

FILE: rtl/core/vohw_queue.sv
// ----------------------------------------------------------------------------
// vohw_queue
// Small job FIFO between the front and back parts. DEPTH of 2 or more.
// ----------------------------------------------------------------------------
module vohw_queue #(
  parameter int DEPTH = vohw_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  vohw_pkg::job_t   in_job,
  output logic             out_valid,
  input  logic             out_ready,
  output vohw_pkg::job_t   out_job
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  vohw_pkg::job_t   slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push, pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_job   = slots[rd_ptr];

  // Store incoming jobs
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= in_job;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/core/vohw_back.sv
// ----------------------------------------------------------------------------
// vohw_back
// Assembles the header bit string of one job and shifts it out a byte a word.
// ----------------------------------------------------------------------------
module vohw_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  output logic             job_ready,
  input  vohw_pkg::job_t   job,
  vohw_hdr_if.source       hdr
);

  vohw_pkg::back_state_t state, state_next;

  logic [vohw_pkg::HDR_W-1:0]    bitstr;
  logic [vohw_pkg::POS_W-1:0]    pos;
  logic [vohw_pkg::POS_W-1:0]    last_pos;

  logic [vohw_pkg::PREFIX_W-1:0] prefix;
  logic [vohw_pkg::TAIL_W-1:0]   tail;
  logic [vohw_pkg::VAR_W-1:0]    var_part;
  logic [vohw_pkg::BITS_W-1:0]   drop;
  logic [7:0]                    nbytes;
  logic                          load, send, last;

  // Fixed fields, start codes through the marker and fixed rate flag after res
  assign prefix = {vohw_pkg::OBJ_CODE, 5'd0, vohw_pkg::LAYER_CODE, 4'd0, 1'b0,
                   8'd1, 1'b1, 4'd2, 3'd1, 4'd1, 1'b0, 2'd0, 1'b1,
                   job.res, 1'b1, 1'b1};
  assign tail   = {1'b1, job.width, 1'b1, job.height, 1'b1, 1'b0, 1'b1, 2'd0,
                   1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0};

  // Left-justify the variable-width increment, drop its unused high bits
  assign drop     = vohw_pkg::BITS_W'(vohw_pkg::RES_W) - job.inc_bits;
  assign var_part = {job.inc, tail} << drop;
  assign nbytes   = (8'(job.inc_bits) + 8'(vohw_pkg::BYTE_BIAS)) >> 3;

  assign job_ready = (state == vohw_pkg::B_IDLE);
  assign load      = job_valid && job_ready;
  assign send      = hdr.valid && hdr.ready;
  assign last      = (pos == last_pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vohw_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      vohw_pkg::B_IDLE: begin
        if (load) state_next = vohw_pkg::B_SEND;
      end
      vohw_pkg::B_SEND: begin
        if (send && last) state_next = vohw_pkg::B_IDLE;
      end
      default: state_next = vohw_pkg::B_IDLE;
    endcase
  end

  // Load the whole header, then advance a byte per accepted word
  always_ff @(posedge clk) begin
    if (load) begin
      bitstr   <= {prefix, var_part, {vohw_pkg::PAD_W{1'b0}}};
      pos      <= '0;
      last_pos <= vohw_pkg::POS_W'(nbytes - 8'd1);
    end else if (send) begin
      bitstr <= {bitstr[vohw_pkg::HDR_W-vohw_pkg::BYTE_W-1:0],
                 {vohw_pkg::BYTE_W{1'b0}}};
      pos    <= pos + vohw_pkg::POS_W'(1);
    end
  end

  assign hdr.valid         = (state == vohw_pkg::B_SEND);
  assign hdr.header_byte   = bitstr[vohw_pkg::HDR_W-1 -: vohw_pkg::BYTE_W];
  assign hdr.byte_position = pos;
  assign hdr.final_byte    = last;

endmodule

FILE: rtl/core/video_object_layer_header_writer_top.sv
// ----------------------------------------------------------------------------
// video_object_layer_header_writer_top
// MPEG-4 video object and video object layer header writer.
//
//   channel  dir  payload                                         word
//   req      in   picture_width, picture_height, time_resolution,
//                 rate_milli                                      one request
//   hdr      out  header_byte, byte_position, final_byte          one byte
//
// A request passes through the front part in order: capture, a scaling step,
// the one-bit-per-cycle divider and a push into the job queue.
// The back part loads a job and sends 19 to 21 bytes, one per
// cycle while hdr.ready is high, so the divider sets the sustained header
// rate. Reset is synchronous and clears all control.
// A stall on hdr fills the queue, then holds req.ready low.
// ----------------------------------------------------------------------------
module video_object_layer_header_writer_top #(
  parameter int QUEUE_DEPTH = vohw_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  vohw_req_if.sink    req,
  vohw_hdr_if.source  hdr
);

  logic           push_valid, push_ready;
  vohw_pkg::job_t push_job;
  logic           job_valid, job_ready;
  vohw_pkg::job_t job;

  vohw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  vohw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .in_job    (push_job),
    .out_valid (job_valid),
    .out_ready (job_ready),
    .out_job   (job)
  );

  vohw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .hdr       (hdr)
  );

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the MPEG-4 VO/VOL header writer. Requests go in
// through the req channel with random gaps. The bench predicts every header
// byte from the request fields: size rounding, increment width and the
// rounded increment, including the zero frame rate case. A scoreboard
// compares each byte that arrives on hdr, in order, with the predicted bytes.
// ----------------------------------------------------------------------------
module tb;

  localparam int IDLE_PCT     = 17;
  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE_CYC   = 60;
  localparam int RANDOM_ITEMS = 152;
  // Twelve closing bits after the height: its marker and the flags
  localparam logic [11:0] TAIL_FLAGS = 12'hA0C;

  typedef struct {
    logic [vohw_pkg::BYTE_W-1:0] value;
    logic [vohw_pkg::POS_W-1:0]  pos;
    logic                        last;
  } hdr_word_t;

  // --------------------------------------------------------------------------
  // Header predictor and byte scoreboard
  // --------------------------------------------------------------------------
  class hdr_scoreboard;
    hdr_word_t                  pending_bytes[$];
    logic [vohw_pkg::HDR_W-1:0] hdr_vec;
    int                         hdr_fill;
    int unsigned                mismatches;
    int unsigned                requests_seen;
    int unsigned                bytes_checked;

    function void put_field(int n, longint unsigned v);
      for (int i = 0; i < n; i++) begin
        if (hdr_fill + i < vohw_pkg::HDR_W)
          hdr_vec[vohw_pkg::HDR_W-1-(hdr_fill+i)] = v[n-1-i];
      end
      hdr_fill += n;
    endfunction

    function logic [vohw_pkg::SIZE_W-1:0] round_size(logic [vohw_pkg::SIZE_W-1:0] v);
      logic [vohw_pkg::SIZE_W:0] sum;
      sum = {1'b0, v} + 14'd8;
      return {sum[vohw_pkg::SIZE_W-1:4], 4'b0000};
    endfunction

    function void note_failure(string what, hdr_word_t exp_w, hdr_word_t got_w);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %0d (%s): expected byte=%02h pos=%0d last=%0b, %s",
                 mismatches, what, exp_w.value, exp_w.pos, exp_w.last,
                 $sformatf("got byte=%02h pos=%0d last=%0b",
                           got_w.value, got_w.pos, got_w.last));
    endfunction

    // Build the whole header for one accepted request and queue its bytes
    function void add_request(logic [vohw_pkg::SIZE_W-1:0] width_in,
                              logic [vohw_pkg::SIZE_W-1:0] height_in,
                              logic [vohw_pkg::RES_W-1:0] res,
                              logic [vohw_pkg::RATE_W-1:0] rate);
      longint unsigned res_l, rate_l, mask, inc;
      int inc_bits, nbytes;
      hdr_word_t w;
      res_l = res;
      rate_l = rate;
      inc_bits = 1;
      while (inc_bits < vohw_pkg::RES_W && (64'd1 << inc_bits) < res_l) inc_bits++;
      mask = (64'd1 << inc_bits) - 1;
      // saturate the increment when the frame rate is zero
      if (rate_l == 0) inc = mask;
      else inc = ((64'd10000 * res_l + rate_l) / (64'd10 * rate_l)) & mask;

      hdr_vec = '0;
      hdr_fill = 0;
      put_field(27, vohw_pkg::OBJ_CODE);
      put_field(5, 0);           // object id
      put_field(28, vohw_pkg::LAYER_CODE);
      put_field(5, 0);           // layer id, random access flag
      put_field(8, 1);           // object type
      put_field(1, 1);           // object layer identifier present
      put_field(4, 2);           // verid
      put_field(3, 1);           // priority
      put_field(4, 1);           // aspect ratio
      put_field(3, 0);           // control params, shape
      put_field(1, 1);           // marker
      put_field(16, res_l);
      put_field(2, 3);           // marker, fixed rate flag
      put_field(inc_bits, inc);
      put_field(1, 1);
      put_field(13, round_size(width_in));
      put_field(1, 1);
      put_field(13, round_size(height_in));
      put_field(12, TAIL_FLAGS);

      nbytes = (hdr_fill + 7) / 8;
      for (int k = 0; k < nbytes; k++) begin
        w.value = hdr_vec[vohw_pkg::HDR_W-1-8*k -: 8];
        w.pos   = k[vohw_pkg::POS_W-1:0];
        w.last  = (k == nbytes - 1);
        pending_bytes.push_back(w);
      end
      requests_seen++;
    endfunction

    // Compare one delivered word with the oldest predicted byte
    function void check_byte(logic [vohw_pkg::BYTE_W-1:0] value,
                             logic [vohw_pkg::POS_W-1:0] pos, logic last);
      hdr_word_t got_w, exp_w;
      got_w.value = value;
      got_w.pos   = pos;
      got_w.last  = last;
      bytes_checked++;
      if (pending_bytes.size() == 0) begin
        exp_w = '{value: 'x, pos: 'x, last: 1'bx};
        note_failure("no byte pending", exp_w, got_w);
      end else begin
        exp_w = pending_bytes.pop_front();
        if (exp_w.value !== got_w.value || exp_w.pos !== got_w.pos ||
            exp_w.last !== got_w.last)
          note_failure("field", exp_w, got_w);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic steady_flow = 1'b0;
  int unsigned zero_rate_sent = 0;
  int unsigned stall_cycles = 0;
  hdr_scoreboard sb = new();

  vohw_req_if req ();
  vohw_hdr_if hdr ();

  video_object_layer_header_writer_top uut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .hdr (hdr)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stall the header sink at random, never during a steady stretch
  always @(posedge clk) begin
    if (rst) begin
      hdr.ready <= 1'b0;
    end else begin
      hdr.ready <= steady_flow || ($urandom_range(99, 0) >= IDLE_PCT);
    end
  end

  // Note accepted requests and check delivered words
  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready)
        sb.add_request(req.picture_width, req.picture_height, req.time_resolution,
                       req.rate_milli);
      if (hdr.valid && hdr.ready)
        sb.check_byte(hdr.header_byte, hdr.byte_position, hdr.final_byte);
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (hdr.valid && hdr.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Offer one request, idling first at random, and hold it until accepted
  task automatic send_request(input logic [vohw_pkg::SIZE_W-1:0] w,
                              input logic [vohw_pkg::SIZE_W-1:0] h,
                              input logic [vohw_pkg::RES_W-1:0] res,
                              input logic [vohw_pkg::RATE_W-1:0] rate);
    while (!steady_flow && $urandom_range(99, 0) < IDLE_PCT) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid           <= 1'b1;
    req.picture_width   <= w;
    req.picture_height  <= h;
    req.time_resolution <= res;
    req.rate_milli      <= rate;
    if (rate == 0) zero_rate_sent++;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  // Hold the sender off until every predicted byte has arrived
  task automatic drain_headers();
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_request();
    logic [vohw_pkg::RES_W-1:0]  res;
    logic [vohw_pkg::RATE_W-1:0] rate;
    int p;
    case ($urandom_range(3, 0))
      0: res = vohw_pkg::RES_W'($urandom_range(20, 0));
      1: begin
        // land on and around powers of two, where the increment width steps
        p = $urandom_range(16, 0);
        res = vohw_pkg::RES_W'((32'd1 << p) + $urandom_range(2, 0) - 32'd1);
      end
      default: res = vohw_pkg::RES_W'($urandom_range(65535, 0));
    endcase
    p = $urandom_range(19, 0);
    if (p == 0) rate = '0;
    else if (p < 8) rate = vohw_pkg::RATE_W'($urandom_range(262143, 1));
    else rate = vohw_pkg::RATE_W'($urandom_range(120000, 1000));
    send_request(vohw_pkg::SIZE_W'($urandom_range(8191, 0)),
                 vohw_pkg::SIZE_W'($urandom_range(8191, 0)), res, rate);
  endtask

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.picture_width = '0;
    req.picture_height = '0;
    req.time_resolution = '0;
    req.rate_milli = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, rounding edges, width steps, zero rate
    send_request(13'd0, 13'd0, 16'd0, 18'd0);
    send_request(13'd8191, 13'd8191, 16'd65535, 18'd262143);
    send_request(13'd176, 13'd144, 16'd1, 18'd1000);
    send_request(13'd7, 13'd8, 16'd2, 18'd1000);
    send_request(13'd8183, 13'd8184, 16'd3, 18'd25000);
    send_request(13'd720, 13'd576, 16'd25, 18'd25000);
    send_request(13'd1920, 13'd1080, 16'd30000, 18'd29970);
    send_request(13'd640, 13'd480, 16'd24000, 18'd23976);
    send_request(13'h1555, 13'h0AAA, 16'h5555, 18'h2AAAA);
    send_request(13'h0AAA, 13'h1555, 16'hAAAA, 18'h15555);
    send_request(13'd352, 13'd288, 16'd32768, 18'd1);
    send_request(13'd352, 13'd288, 16'd32769, 18'd1000);
    send_request(13'd100, 13'd100, 16'd65535, 18'd0);
    send_request(13'd100, 13'd100, 16'd1, 18'd0);
    send_request(13'd1280, 13'd720, 16'd1, 18'd262143);
    send_request(13'd24, 13'd40, 16'd16, 18'd1);
    send_request(13'd8, 13'd8, 16'd17, 18'd1);
    send_request(13'd1024, 13'd768, 16'd60, 18'd60000);
    drain_headers();

    // Random requests, with a steady stretch and a second full drain
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_flow = (n >= 50 && n < 90);
      send_random_request();
      if (n == 110) drain_headers();
    end
    steady_flow = 1'b0;
    drain_headers();
    repeat (SETTLE_CYC) @(posedge clk);

    $display("Covered %0d requests (%0d with zero frame rate), %0d header bytes compared.",
             sb.requests_seen, zero_rate_sent, sb.bytes_checked);
    $display("Mismatches: %0d, bytes still pending: %0d", sb.mismatches,
             sb.pending_bytes.size());
    if (sb.mismatches == 0 && sb.pending_bytes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
